// ----- src/wtsp_pkg.sv -----
// shared types, constants and helper functions for the world-to-screen projection
package wtsp_pkg;

   localparam int COORD_W = 32;
   localparam int PROD_W = 64;
   localparam int FLOOR_W = 48;
   localparam int CLIP_W = 51;
   localparam int SUM_W = 52;
   localparam int SCALE_W = 16;
   localparam int NUM_W = 68;
   localparam int MAG_W = 67;
   localparam int DEN_W = 52;
   localparam int QUO_W = 33;
   localparam int FRAC_SHIFT = 16;
   localparam int PAIR_COUNT = 8;
   localparam int INDEX_W = 3;
   localparam int PAIR_W = 64;
   localparam int DIV_STEPS = QUO_W;
   localparam logic signed [CLIP_W-1:0] W_MIN_Q = CLIP_W'(6554);

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] bits;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type     lx;
      div_lane_type     ly;
      logic [DEN_W-1:0] den;
      logic             visible;
   } div_item_type;

   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [DEN_W-1:0] den);
      div_lane_type  r;
      logic [DEN_W:0] t;
      logic [DEN_W:0] diff;
      r = lane;
      t = {lane.rem, lane.bits[QUO_W-1]};
      diff = t - {1'b0, den};
      if (t >= {1'b0, den}) begin
         r.rem = diff[DEN_W-1:0];
         r.quo = {lane.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = t[DEN_W-1:0];
         r.quo = {lane.quo[QUO_W-2:0], 1'b0};
      end
      r.bits = {lane.bits[QUO_W-2:0], 1'b0};
      return r;
   endfunction

   // round half away from zero, then saturate to signed 32 bits
   function automatic logic [COORD_W-1:0] lane_result(input div_lane_type lane);
      logic [QUO_W:0]   inc;
      logic [QUO_W-1:0] mag;
      logic [COORD_W-1:0] res;
      inc = {1'b0, lane.quo} + (QUO_W+1)'(1);
      mag = inc[QUO_W:1];
      if (lane.neg) begin
         if (lane.ovf || mag > QUO_W'(33'h0_8000_0000)) begin
            res = 32'h8000_0000;
         end else begin
            res = 32'(~mag + QUO_W'(1));
         end
      end else begin
         if (lane.ovf || mag > QUO_W'(33'h0_7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
         end else begin
            res = mag[COORD_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ----- src/wtsp_req_if.sv -----
// point request channel
interface wtsp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wtsp_pkg::COORD_W-1:0] pos_x;
   logic signed [wtsp_pkg::COORD_W-1:0] pos_y;
   logic signed [wtsp_pkg::COORD_W-1:0] pos_z;
   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ----- src/wtsp_rsp_if.sv -----
// screen response channel
interface wtsp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wtsp_pkg::COORD_W-1:0] screen_x;
   logic signed [wtsp_pkg::COORD_W-1:0] screen_y;
   logic                                 visible;
   modport source (output valid, output screen_x, output screen_y, output visible,
                   input ready);
   modport sink (input valid, input screen_x, input screen_y, input visible,
                 output ready);
endinterface

// ----- src/wtsp_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
module wtsp_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  wtsp_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output wtsp_pkg::div_item_type out_item
);

   localparam int N = wtsp_pkg::DIV_STEPS;

   logic                   valid_ff [N];
   wtsp_pkg::div_item_type item_ff [N];
   logic                   en [N];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_stage
         wtsp_pkg::div_item_type src;
         wtsp_pkg::div_item_type item_in;
         logic                   src_valid;
         logic                   down_ready;
         if (k == 0) begin : g_first
            assign src = in_item;
            assign src_valid = in_valid;
         end else begin : g_next
            assign src = item_ff[k-1];
            assign src_valid = valid_ff[k-1];
         end
         if (k == N-1) begin : g_last
            assign down_ready = out_ready;
         end else begin : g_mid
            assign down_ready = en[k+1];
         end
         assign en[k] = !valid_ff[k] || down_ready;

         always_comb begin
            item_in = src;
            item_in.lx = wtsp_pkg::div_step(src.lx, src.den);
            item_in.ly = wtsp_pkg::div_step(src.ly, src.den);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en[k]) begin
               valid_ff[k] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en[k] && src_valid) begin
               item_ff[k] <= item_in;
            end
         end
      end
   endgenerate

   assign in_ready = en[0];
   assign out_valid = valid_ff[N-1];
   assign out_item = item_ff[N-1];

endmodule

// ----- src/world_to_screen_projection.sv -----
// top level: matrix transform, visibility test, viewport divide and saturation
// throughput: one point per cycle unless rsp_bus.ready stalls the output
// the 33-stage one-bit-per-stage divider sets the depth
// each stage holds its beat only while it and all stages below it are full
// synchronous reset clears every valid bit and zeroes the matrix registers
module world_to_screen_projection #(
   parameter int SCREEN_WIDTH = 1920,
   parameter int SCREEN_HEIGHT = 1080
) (
   input  logic                             clock,
   input  logic                             reset,
   wtsp_req_if.sink                         req_bus,
   wtsp_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [wtsp_pkg::INDEX_W-1:0]     csr_index,
   input  logic [wtsp_pkg::PAIR_W-1:0]      csr_wdata
);

   localparam logic signed [wtsp_pkg::SCALE_W-1:0] SW = wtsp_pkg::SCALE_W'(SCREEN_WIDTH);
   localparam logic signed [wtsp_pkg::SCALE_W-1:0] SH = wtsp_pkg::SCALE_W'(SCREEN_HEIGHT);

   logic [wtsp_pkg::PAIR_W-1:0] pair_ff [wtsp_pkg::PAIR_COUNT];
   logic signed [wtsp_pkg::COORD_W-1:0] m [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wtsp_pkg::PAIR_COUNT; i++) pair_ff[i] <= '0;
      end else if (csr_we) begin
         pair_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int e = 0; e < 16; e++) begin
         m[e] = (e % 2 == 1) ? pair_ff[e/2][63:32] : pair_ff[e/2][31:0];
      end
   end

   // stage control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic en1, en2, en3, en4, en5, out_en;
   logic div_in_ready, div_out_valid;
   wtsp_pkg::div_item_type div_in, div_out;

   assign out_en = !out_v_ff || rsp_bus.ready;
   assign en5 = !v5_ff || div_in_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (out_en) out_v_ff <= div_out_valid;
      end
   end

   // stage 1: nine products
   logic signed [wtsp_pkg::PROD_W-1:0] prod_ff [9];
   logic signed [wtsp_pkg::PROD_W-1:0] prod_in [9];

   always_comb begin
      prod_in[0] = req_bus.pos_x * m[0];
      prod_in[1] = req_bus.pos_y * m[4];
      prod_in[2] = req_bus.pos_z * m[8];
      prod_in[3] = req_bus.pos_x * m[1];
      prod_in[4] = req_bus.pos_y * m[5];
      prod_in[5] = req_bus.pos_z * m[9];
      prod_in[6] = req_bus.pos_x * m[3];
      prod_in[7] = req_bus.pos_y * m[7];
      prod_in[8] = req_bus.pos_z * m[11];
   end

   always_ff @(posedge clock) begin
      if (en1 && req_bus.valid) begin
         for (int i = 0; i < 9; i++) prod_ff[i] <= prod_in[i];
      end
   end

   // stage 2: floor and sum into clip x, y, w
   logic signed [wtsp_pkg::CLIP_W-1:0] cx_ff, cy_ff, cw_ff, cx_in, cy_in, cw_in;
   logic signed [wtsp_pkg::FLOOR_W-1:0] fl [9];

   always_comb begin
      for (int i = 0; i < 9; i++) fl[i] = prod_ff[i][wtsp_pkg::PROD_W-1:wtsp_pkg::FRAC_SHIFT];
      cx_in = wtsp_pkg::CLIP_W'(m[12]) + wtsp_pkg::CLIP_W'(fl[0])
            + wtsp_pkg::CLIP_W'(fl[1]) + wtsp_pkg::CLIP_W'(fl[2]);
      cy_in = wtsp_pkg::CLIP_W'(m[13]) + wtsp_pkg::CLIP_W'(fl[3])
            + wtsp_pkg::CLIP_W'(fl[4]) + wtsp_pkg::CLIP_W'(fl[5]);
      cw_in = wtsp_pkg::CLIP_W'(m[15]) + wtsp_pkg::CLIP_W'(fl[6])
            + wtsp_pkg::CLIP_W'(fl[7]) + wtsp_pkg::CLIP_W'(fl[8]);
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cw_ff <= cw_in;
      end
   end

   // stage 3: visibility, numerator sums and divisor
   logic signed [wtsp_pkg::SUM_W-1:0] sx_ff, sy_ff;
   logic [wtsp_pkg::DEN_W-1:0] den3_ff, den4_ff;
   logic vis3_ff, vis4_ff;

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         sx_ff <= wtsp_pkg::SUM_W'(cw_ff) + wtsp_pkg::SUM_W'(cx_ff);
         sy_ff <= wtsp_pkg::SUM_W'(cw_ff) - wtsp_pkg::SUM_W'(cy_ff);
         den3_ff <= {cw_ff[wtsp_pkg::DEN_W-2:0], 1'b0};
         vis3_ff <= cw_ff >= wtsp_pkg::W_MIN_Q;
      end
   end

   // stage 4: viewport scale
   logic signed [wtsp_pkg::NUM_W-1:0] nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         nx_ff <= wtsp_pkg::NUM_W'(sx_ff) * wtsp_pkg::NUM_W'(SW);
         ny_ff <= wtsp_pkg::NUM_W'(sy_ff) * wtsp_pkg::NUM_W'(SH);
         den4_ff <= den3_ff;
         vis4_ff <= vis3_ff;
      end
   end

   // stage 5: magnitude, overflow check and divider seed
   function automatic wtsp_pkg::div_lane_type seed(input logic signed [wtsp_pkg::NUM_W-1:0] n,
                                                   input logic [wtsp_pkg::DEN_W-1:0] den);
      wtsp_pkg::div_lane_type r;
      logic [wtsp_pkg::NUM_W-1:0] a;
      a = n[wtsp_pkg::NUM_W-1] ? (~n + wtsp_pkg::NUM_W'(1)) : n;
      r.neg = n[wtsp_pkg::NUM_W-1];
      r.rem = wtsp_pkg::DEN_W'(a[wtsp_pkg::MAG_W-1:wtsp_pkg::FRAC_SHIFT]);
      r.ovf = r.rem >= den;
      r.bits = {a[wtsp_pkg::FRAC_SHIFT-1:0], (wtsp_pkg::QUO_W-wtsp_pkg::FRAC_SHIFT)'(0)};
      r.quo = '0;
      return r;
   endfunction

   wtsp_pkg::div_item_type seed_ff, seed_in;

   always_comb begin
      seed_in.lx = seed(nx_ff, den4_ff);
      seed_in.ly = seed(ny_ff, den4_ff);
      seed_in.den = den4_ff;
      seed_in.visible = vis4_ff;
   end

   always_ff @(posedge clock) begin
      if (en5 && v4_ff) seed_ff <= seed_in;
   end

   assign div_in = seed_ff;

   wtsp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_ready  (div_in_ready),
      .in_item   (div_in),
      .out_valid (div_out_valid),
      .out_ready (out_en),
      .out_item  (div_out)
   );

   // output register
   logic [wtsp_pkg::COORD_W-1:0] scr_x_ff, scr_y_ff;
   logic vis_ff;

   always_ff @(posedge clock) begin
      if (out_en && div_out_valid) begin
         vis_ff <= div_out.visible;
         scr_x_ff <= div_out.visible ? wtsp_pkg::lane_result(div_out.lx) : '0;
         scr_y_ff <= div_out.visible ? wtsp_pkg::lane_result(div_out.ly) : '0;
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.screen_x = scr_x_ff;
   assign rsp_bus.screen_y = scr_y_ff;
   assign rsp_bus.visible = vis_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !vis_ff |-> scr_x_ff == '0 && scr_y_ff == '0)
      else $error("invisible point with nonzero screen position");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v1_ff)
      else $error("accepted beat did not reach first stage");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      div_out_valid && !out_en |=> div_out_valid && $stable(div_out))
      else $error("divider output lost while stalled");

endmodule
